// File: rtl/mpbm_pkg.sv
// Shared types and constants of the multi-pattern byte matcher.
`timescale 1ns / 1ps
package mpbm_pkg;
	localparam int unsigned STATE_CAP_DEF = 1024;
	localparam int unsigned EDGE_CAP_DEF  = 4096;
	localparam int unsigned MAX_LEN_DEF   = 255;

	typedef enum logic [1:0] {
		REQ_SEARCH  = 2'd0,
		REQ_WR_STATE = 2'd1,
		REQ_WR_EDGE = 2'd2,
		REQ_RESTART = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCAN,
		ST_ERD,
		ST_ECMP,
		ST_LRD,
		ST_OUT
	} fsm_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  data_byte;
		logic [9:0]  state_index;
		logic [9:0]  fail_target;
		logic [7:0]  pattern_length;
		logic [11:0] edge_base;
		logic [8:0]  edge_total;
		logic [11:0] edge_slot;
		logic [7:0]  edge_label;
		logic [9:0]  edge_target;
		logic [31:0] start_position;
	} req_beat_t;

	typedef struct packed {
		logic        matched;
		logic [9:0]  pattern_id;
		logic [31:0] match_start;
		logic [31:0] match_end;
		logic [9:0]  state_after;
	} res_beat_t;
endpackage

// File: rtl/mpbm_if.sv
// Valid/ready channel carrying one beat of payload.
`timescale 1ns / 1ps
interface mpbm_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/multi_pattern_byte_matcher_top.sv
// Aho-Corasick matcher: one byte in, edge scan and fail walk through memory.
// Table writes and restarts are taken in idle and give no result. A search reads each state
// on the fail chain, then reads and compares its edges, skipping edge indices past the table;
// after a hit, or a miss at the root, it reads the landed state's length and loads the result
// once the output is free; the next beat is taken in the cycle after. Memory reads are registered.
// Reset: current state root, position 0, case folding off; tables undefined until written.
`timescale 1ns / 1ps
module multi_pattern_byte_matcher_top
	import mpbm_pkg::*;
#(
	parameter int unsigned STATE_CAPACITY    = STATE_CAP_DEF,
	parameter int unsigned EDGE_CAPACITY     = EDGE_CAP_DEF,
	parameter int unsigned MAX_PATTERN_BYTES = MAX_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	mpbm_if.sink   req,
	mpbm_if.source res
);
	localparam int unsigned SW = (STATE_CAPACITY > 1) ? $clog2(STATE_CAPACITY) : 1;
	localparam int unsigned EW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
	localparam int unsigned CW = $clog2(STATE_CAPACITY + 1);
	localparam logic [7:0] MAXL = (MAX_PATTERN_BYTES > 255) ? 8'd255 : 8'(MAX_PATTERN_BYTES);

	fsm_t state_q, state_d;
	logic        ci_q;
	logic [9:0]  cur_q;
	logic [31:0] pos_q;
	logic [7:0]  c_q;
	logic [9:0]  s_q;
	logic [9:0]  fail_q;
	logic [11:0] base_q;
	logic [8:0]  total_q;
	logic [8:0]  i_q;
	logic [CW-1:0] steps_q;
	logic [9:0]  next_q;
	logic        found_q;
	logic        out_v_q;
	res_beat_t   out_q;

	logic        st_we, ed_we;
	logic [SW-1:0] st_raddr;
	logic [38:0] st_rdata;
	logic [EW-1:0] ed_raddr;
	logic [17:0] ed_rdata;
	logic [12:0] eidx;
	logic [11:0] base_cur;
	logic [8:0]  total_cur;
	logic        accept;
	logic        out_load;
	req_beat_t   b;

	assign b      = req.data;
	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign res.valid = out_v_q;
	assign res.data  = out_q;
	// load a new result once the held one is gone or leaves this cycle
	assign out_load  = (state_q == ST_OUT) && (!out_v_q || res.ready);

	// first scan cycle of a state takes its entry straight from the memory
	assign base_cur  = (state_q == ST_SCAN && i_q == 9'd0) ? st_rdata[20:9] : base_q;
	assign total_cur = (state_q == ST_SCAN && i_q == 9'd0) ? st_rdata[8:0] : total_q;

	assign eidx  = {1'b0, base_cur} + {4'd0, i_q};
	assign st_we = accept && (req_t'(b.req_type) == REQ_WR_STATE)
		&& ({22'd0, b.state_index} < STATE_CAPACITY);
	assign ed_we = accept && (req_t'(b.req_type) == REQ_WR_EDGE)
		&& ({20'd0, b.edge_slot} < EDGE_CAPACITY);

	function automatic logic [9:0] clamp_s(input logic [9:0] v);
		return ({22'd0, v} < STATE_CAPACITY) ? v : 10'd0;
	endfunction

	// Read address: state being scanned, or the landed state for its length.
	always_comb begin
		st_raddr = SW'(s_q);
		if (state_q == ST_ECMP || state_q == ST_LRD || state_q == ST_OUT) begin
			st_raddr = SW'(next_q);
		end
	end
	assign ed_raddr = EW'(eidx);

	mpbm_state_mem #(.STATE_CAPACITY(STATE_CAPACITY)) u_st (
		.clk(clk), .we(st_we), .waddr(SW'(b.state_index)),
		.wdata({b.fail_target, (b.pattern_length > MAXL) ? MAXL : b.pattern_length,
			b.edge_base, b.edge_total}),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	mpbm_edge_mem #(.EDGE_CAPACITY(EDGE_CAPACITY)) u_ed (
		.clk(clk), .we(ed_we), .waddr(EW'(b.edge_slot)),
		.wdata({b.edge_label, b.edge_target}),
		.raddr(ed_raddr), .rdata(ed_rdata)
	);

	logic scan_done, idx_ok, hit;
	assign scan_done = (i_q >= total_cur);
	assign idx_ok    = ({19'd0, eidx} < EDGE_CAPACITY);
	assign hit       = (ed_rdata[17:10] == c_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && req_t'(b.req_type) == REQ_SEARCH) begin
					state_d = ST_SRD;
				end
			end
			ST_SRD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_done) begin
					state_d = (s_q == 10'd0) ? ST_LRD : ST_SRD;
				end else if (idx_ok) begin
					state_d = ST_ERD;
				end
			end
			ST_ERD: state_d = ST_ECMP;
			ST_ECMP: state_d = hit ? ST_LRD : ST_SCAN;
			ST_LRD: state_d = ST_OUT;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ci_q    <= 1'b0;
			cur_q   <= 10'd0;
			pos_q   <= 32'd0;
			out_v_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				ci_q <= cfg_wdata;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && req_t'(b.req_type) == REQ_RESTART) begin
						cur_q <= 10'd0;
						pos_q <= b.start_position;
					end
					if (accept && req_t'(b.req_type) == REQ_SEARCH) begin
						found_q <= 1'b0;
						next_q  <= 10'd0;
						steps_q <= '0;
						s_q     <= clamp_s(cur_q);
						c_q     <= (ci_q && b.data_byte >= 8'h41 && b.data_byte <= 8'h5A)
							? b.data_byte + 8'h20 : b.data_byte;
					end
				end
				ST_SRD: i_q <= 9'd0;
				ST_SCAN: begin
					if (i_q == 9'd0) begin
						fail_q  <= st_rdata[38:29];
						base_q  <= st_rdata[20:9];
						total_q <= st_rdata[8:0];
					end
					if (scan_done) begin
						// advance along the fail chain
						if (s_q != 10'd0) begin
							steps_q <= steps_q + 1'b1;
							s_q <= (CW'(steps_q + 1'b1) >= CW'(STATE_CAPACITY)) ? 10'd0
								: clamp_s((i_q == 9'd0) ? st_rdata[38:29] : fail_q);
						end
					end else if (!idx_ok) begin
						// skip an edge index past the table
						i_q <= i_q + 1'b1;
					end
				end
				ST_ECMP: begin
					if (hit) begin
						found_q <= 1'b1;
						next_q  <= clamp_s(ed_rdata[9:0]);
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						cur_q   <= next_q;
						pos_q   <= pos_q + 32'd1;
						out_q.state_after <= next_q;
						if (found_q && st_rdata[28:21] != 8'd0) begin
							out_q.matched     <= 1'b1;
							out_q.pattern_id  <= next_q;
							out_q.match_start <= pos_q - {24'd0, st_rdata[28:21]} + 32'd1;
							out_q.match_end   <= pos_q + 32'd1;
						end else begin
							out_q.matched     <= 1'b0;
							out_q.pattern_id  <= 10'd0;
							out_q.match_start <= 32'd0;
							out_q.match_end   <= 32'd0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// File: rtl/mpbm_state_mem.sv
// State entry memory: fail link, pattern length, edge base, edge count.
`timescale 1ns / 1ps
module mpbm_state_mem
	import mpbm_pkg::*;
#(
	parameter int unsigned STATE_CAPACITY = STATE_CAP_DEF,
	parameter int unsigned SW = (STATE_CAPACITY > 1) ? $clog2(STATE_CAPACITY) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [SW-1:0] waddr,
	input  logic [38:0]   wdata,
	input  logic [SW-1:0] raddr,
	output logic [38:0]   rdata
);
	logic [38:0] mem [STATE_CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/mpbm_edge_mem.sv
// Edge entry memory: label and target state.
`timescale 1ns / 1ps
module mpbm_edge_mem
	import mpbm_pkg::*;
#(
	parameter int unsigned EDGE_CAPACITY = EDGE_CAP_DEF,
	parameter int unsigned EW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [EW-1:0] waddr,
	input  logic [17:0]   wdata,
	input  logic [EW-1:0] raddr,
	output logic [17:0]   rdata
);
	logic [17:0] mem [EDGE_CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
